// File: src/assert_macros.svh
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/sacl_pkg.sv
`default_nettype none

package sacl_pkg;

   // Default geometry limits
   localparam int MAX_SET_BITS_DEF = 6;
   localparam int MAX_WAYS_DEF     = 8;

   // Field widths
   localparam int ADDR_W  = 64;
   localparam int STAMP_W = 64;
   localparam int COUNT_W = 32;
   localparam int CMD_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   // Commands
   typedef logic [CMD_W-1:0] cmd_type;
   localparam cmd_type CMD_LOAD   = 2'd0;
   localparam cmd_type CMD_STORE  = 2'd1;
   localparam cmd_type CMD_MODIFY = 2'd2;
   localparam cmd_type CMD_FETCH  = 2'd3;

   // Access outcomes
   typedef logic [1:0] outcome_type;
   localparam outcome_type OUT_HIT   = 2'd0;
   localparam outcome_type OUT_MISS  = 2'd1;
   localparam outcome_type OUT_EVICT = 2'd2;

   // Register indexes
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_SET_BITS   = 2'd0;
   localparam csr_idx_type CSR_BLOCK_BITS = 2'd1;
   localparam csr_idx_type CSR_WAYS       = 2'd2;

   // Result payload, last field in the lowest bits
   typedef struct packed {
      logic [5:0]         pad;
      logic [COUNT_W-1:0] eviction_total;
      logic [COUNT_W-1:0] miss_total;
      logic [COUNT_W-1:0] hit_total;
      outcome_type        outcome;
   } rsp_data_type;

endpackage

`default_nettype wire

// File: src/sacl_mem.sv
`default_nettype none

// Single-port-write, single-port-read row store with registered read data
module sacl_mem #(
   parameter int WIDTH = sacl_pkg::MAX_WAYS_DEF * (1 + sacl_pkg::ADDR_W + sacl_pkg::STAMP_W),
   parameter int DEPTH = 1 << sacl_pkg::MAX_SET_BITS_DEF,
   parameter int AW    = (sacl_pkg::MAX_SET_BITS_DEF > 0) ? sacl_pkg::MAX_SET_BITS_DEF : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] row_mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered, holds when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= row_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/sacl_way_sel.sv
`default_nettype none

// Tag match, free-way search and LRU victim choice over one set
module sacl_way_sel #(
   parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF
) (
   input  wire logic [MAX_WAYS-1:0]                        valid,
   input  wire logic [MAX_WAYS-1:0][sacl_pkg::ADDR_W-1:0]  tag_row,
   input  wire logic [MAX_WAYS-1:0][sacl_pkg::STAMP_W-1:0] stamp_row,
   input  wire logic [sacl_pkg::ADDR_W-1:0]                tag_in,
   input  wire logic [3:0]                                 nw,
   output sacl_pkg::outcome_type                           outcome,
   output logic      [MAX_WAYS-1:0]                        sel
);

   logic [MAX_WAYS-1:0] in_use;
   logic [MAX_WAYS-1:0] hit;
   logic [MAX_WAYS-1:0] free;
   logic [MAX_WAYS-1:0] oldest;

   function automatic logic [MAX_WAYS-1:0] lowest(input logic [MAX_WAYS-1:0] x);
      return x & (~x + 1'b1);
   endfunction

   // Per-way match and free flags
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w] = (w < int'(nw));
         hit[w]    = in_use[w] && valid[w] && (tag_row[w] == tag_in);
         free[w]   = in_use[w] && !valid[w];
      end
   end

   // Pairwise stamp compare: a way wins if strictly older than lower ways
   // and no younger than higher ones, so ties go to the lowest way
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         oldest[w] = in_use[w];
         for (int j = 0; j < MAX_WAYS; j++) begin
            if (j != w && in_use[j]) begin
               if (j < w) begin
                  oldest[w] = oldest[w] && (stamp_row[w] < stamp_row[j]);
               end else begin
                  oldest[w] = oldest[w] && !(stamp_row[j] < stamp_row[w]);
               end
            end
         end
      end
   end

   // Hit first, then first free way, then the LRU way
   always_comb begin
      priority if (|hit) begin
         outcome = sacl_pkg::OUT_HIT;
         sel     = lowest(hit);
      end else if (|free) begin
         outcome = sacl_pkg::OUT_MISS;
         sel     = lowest(free);
      end else begin
         outcome = sacl_pkg::OUT_EVICT;
         sel     = lowest(oldest);
      end
   end

endmodule

`default_nettype wire

// File: src/set_assoc_lru_cache_sim.sv
// An accepted request reads its set row; the update then writes it back and registers the result.
// Load and store make one read-update pass, modify two, with req_tready low until done; fetch is dropped;
// each access is one read of the set row from the memory port and one write back.
// A result waiting at the output stalls the update cycle, not acceptance of the next item.
// Reset: synchronous; a clearing pass over all 2**MAX_SET_BITS rows (64 by default) then follows,
// with req_tready low, while configuration writes are taken as usual.
`default_nettype none
`include "assert_macros.svh"

module set_assoc_lru_cache_sim #(
   parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = sacl_pkg::MAX_WAYS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request: tdata = address[63:0]; tuser = command[1:0]
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [sacl_pkg::ADDR_W-1:0]     req_tdata,
   input  wire logic [sacl_pkg::CMD_W-1:0]      req_tuser,
   // response: tdata = outcome[1:0], hit_total[33:2], miss_total[65:34],
   // eviction_total[97:66], zero pad[103:98]; tlast = last_of_run
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [103:0]                         rsp_tdata,
   output logic                                 rsp_tlast,
   // configuration write port
   input  wire logic                            csr_we,
   input  wire logic [sacl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sacl_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int ROWS  = 1 << MAX_SET_BITS;

   typedef struct packed {
      logic [MAX_WAYS-1:0]                        valid;
      logic [MAX_WAYS-1:0][sacl_pkg::ADDR_W-1:0]  tag;
      logic [MAX_WAYS-1:0][sacl_pkg::STAMP_W-1:0] stamp;
   } row_type;

   localparam int ROW_W = $bits(row_type);

   // Sequencer states
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_LOOK  = 2'd2;
   localparam logic [1:0] ST_READ2 = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;
   logic second_ff, second_in;

   logic [2:0] set_bits_ff;
   logic [5:0] block_bits_ff;
   logic [3:0] ways_ff;

   logic [sacl_pkg::STAMP_W-1:0] stamp_ff, stamp_in;
   logic [sacl_pkg::COUNT_W-1:0] hit_ff, hit_in;
   logic [sacl_pkg::COUNT_W-1:0] miss_ff, miss_in;
   logic [sacl_pkg::COUNT_W-1:0] evict_ff, evict_in;

   logic rsp_valid_ff, rsp_valid_in;
   sacl_pkg::rsp_data_type rsp_data_ff, rsp_data_in;
   logic rsp_last_ff, rsp_last_in;

   logic [sacl_pkg::ADDR_W-1:0] tag_ff;
   logic [IDX_W-1:0]            idx_ff;
   sacl_pkg::cmd_type           cmd_ff;

   // address split
   logic [2:0]                  sb_eff;
   logic [3:0]                  nw;
   logic [6:0]                  shift_sum;
   logic [sacl_pkg::ADDR_W-1:0] off_sh;
   logic [sacl_pkg::ADDR_W-1:0] tag_c;
   logic [IDX_W-1:0]            idx_c;

   // memory ports
   logic             mem_we;
   logic [IDX_W-1:0] mem_wr_addr;
   row_type          wr_row;
   logic             mem_re;
   logic [IDX_W-1:0] mem_rd_addr;
   logic [ROW_W-1:0] rd_vec;
   row_type          rd_row;

   sacl_pkg::outcome_type outcome;
   logic [MAX_WAYS-1:0]   way_sel;
   logic                  accept;
   logic                  look_go;
   logic [sacl_pkg::STAMP_W-1:0] next_stamp;

   // Effective geometry
   always_comb begin
      sb_eff = (int'(set_bits_ff) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_ff;
      if (ways_ff == 4'd0) begin
         nw = 4'd1;
      end else if (int'(ways_ff) > MAX_WAYS) begin
         nw = 4'(MAX_WAYS);
      end else begin
         nw = ways_ff;
      end
   end

   // Tag and set index of the incoming address
   always_comb begin
      shift_sum = {4'd0, sb_eff} + {1'b0, block_bits_ff};
      tag_c     = (shift_sum >= 7'd64) ? '0 : (req_tdata >> shift_sum);
      off_sh    = req_tdata >> block_bits_ff;
      for (int i = 0; i < IDX_W; i++) begin
         idx_c[i] = (i < int'(sb_eff)) && off_sh[i];
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign look_go    = (state_ff == ST_LOOK) && (!rsp_valid_ff || rsp_tready);
   assign next_stamp = stamp_ff + 1'b1;
   assign rd_row     = row_type'(rd_vec);

   sacl_mem #(
      .WIDTH (ROW_W),
      .DEPTH (ROWS),
      .AW    (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wr_addr),
      .wr_data (ROW_W'(wr_row)),
      .rd_en   (mem_re),
      .rd_addr (mem_rd_addr),
      .rd_data (rd_vec)
   );

   sacl_way_sel #(
      .MAX_WAYS (MAX_WAYS)
   ) u_way_sel (
      .valid     (rd_row.valid),
      .tag_row   (rd_row.tag),
      .stamp_row (rd_row.stamp),
      .tag_in    (tag_ff),
      .nw        (nw),
      .outcome   (outcome),
      .sel       (way_sel)
   );

   // Sequencer: clear pass, read, update and write back
   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      second_in    = second_ff;
      stamp_in     = stamp_ff;
      hit_in       = hit_ff;
      miss_in      = miss_ff;
      evict_in     = evict_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_wr_addr  = idx_ff;
      wr_row       = rd_row;
      mem_re       = 1'b0;
      mem_rd_addr  = idx_ff;

      for (int w = 0; w < MAX_WAYS; w++) begin
         if (way_sel[w]) begin
            wr_row.valid[w] = 1'b1;
            wr_row.tag[w]   = tag_ff;
            wr_row.stamp[w] = next_stamp;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_wr_addr = clr_idx_ff;
            wr_row      = '0;
            clr_idx_in  = clr_idx_ff + 1'b1;
            if (clr_idx_ff == IDX_W'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // instruction fetches are taken and dropped
            if (req_tvalid && req_tuser != sacl_pkg::CMD_FETCH) begin
               mem_re      = 1'b1;
               mem_rd_addr = idx_c;
               second_in   = 1'b0;
               state_in    = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (look_go) begin
               mem_we   = 1'b1;
               stamp_in = next_stamp;
               if (outcome == sacl_pkg::OUT_HIT) begin
                  hit_in = (hit_ff == '1) ? hit_ff : hit_ff + 1'b1;
               end else begin
                  miss_in = (miss_ff == '1) ? miss_ff : miss_ff + 1'b1;
               end
               if (outcome == sacl_pkg::OUT_EVICT) begin
                  evict_in = (evict_ff == '1) ? evict_ff : evict_ff + 1'b1;
               end
               rsp_valid_in               = 1'b1;
               rsp_data_in.pad            = '0;
               rsp_data_in.outcome        = outcome;
               rsp_data_in.hit_total      = hit_in;
               rsp_data_in.miss_total     = miss_in;
               rsp_data_in.eviction_total = evict_in;
               if (cmd_ff == sacl_pkg::CMD_MODIFY && !second_ff) begin
                  rsp_last_in = 1'b0;
                  second_in   = 1'b1;
                  state_in    = ST_READ2;
               end else begin
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         ST_READ2: begin
            // second access of a modify re-reads the freshly written row
            mem_re   = 1'b1;
            state_in = ST_LOOK;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         second_ff     <= 1'b0;
         stamp_ff      <= '0;
         hit_ff        <= '0;
         miss_ff       <= '0;
         evict_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         set_bits_ff   <= 3'd0;
         block_bits_ff <= 6'd0;
         ways_ff       <= 4'd1;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         second_ff    <= second_in;
         stamp_ff     <= stamp_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         evict_ff     <= evict_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               sacl_pkg::CSR_SET_BITS:   set_bits_ff   <= csr_wdata[2:0];
               sacl_pkg::CSR_BLOCK_BITS: block_bits_ff <= csr_wdata[5:0];
               sacl_pkg::CSR_WAYS:       ways_ff       <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         tag_ff <= tag_c;
         idx_ff <= idx_c;
         cmd_ff <= req_tuser;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   `ASSERT_IMPLY(a_sel_onehot, clock, reset, state_ff == ST_LOOK, $onehot(way_sel), "way select not one-hot")
   `ASSERT_NEXT(a_stamp_step, clock, reset, look_go, stamp_ff == $past(stamp_ff) + 64'd1, "stamp did not advance by one")
   `ASSERT_NEXT(a_hit_mono, clock, reset, !reset, hit_ff >= $past(hit_ff), "hit total went down")
   `ASSERT_IMPLY(a_first_of_pair, clock, reset, rsp_tvalid && !rsp_tlast, cmd_ff == sacl_pkg::CMD_MODIFY, "non-final result outside a modify")

endmodule

`default_nettype wire
